// ===== rtl/vfv_pkg.sv =====
`timescale 1ns / 1ps

package vfv_pkg;

	// default chunk geometry
	localparam int CHUNK_WIDTH_DEF  = 16;
	localparam int CHUNK_HEIGHT_DEF = 128;

	// item opcodes
	localparam logic [1:0] OP_WR_CELL = 2'd0;
	localparam logic [1:0] OP_WR_EDGE = 2'd1;
	localparam logic [1:0] OP_QUERY   = 2'd2;

	// block types
	localparam logic [1:0] TYPE_AIR   = 2'd0;
	localparam logic [1:0] TYPE_SOLID = 2'd1;
	localparam logic [1:0] TYPE_WATER = 2'd2;

	// neighbor sides, also bit positions of the presence register
	localparam int SIDE_PZ = 0;
	localparam int SIDE_NZ = 1;
	localparam int SIDE_PX = 2;
	localparam int SIDE_NX = 3;

	// write strobes toward the cell stores
	typedef struct packed {
		logic cell_we;
		logic edge_we;
	} vfv_mem_ctl_t;

	// face shows when the neighbor is air, or water seen from a solid cell
	function automatic logic shows(input logic [1:0] self_type, input logic [1:0] nb_type);
		return (nb_type == TYPE_AIR) || ((nb_type == TYPE_WATER) && (self_type == TYPE_SOLID));
	endfunction

endpackage

// ===== rtl/voxel_face_visibility.sv =====
`timescale 1ns / 1ps
// Query: a beat taken inside the chunk runs S_READ through the self and neighbor reads, then S_TAIL
//   raises done with face_mask; a query outside the chunk returns mask 0 in the next cycle.
// A new beat is taken only while not busy, as each store has a single read port
//   (self cell plus six neighbors, one read a cycle); writes are likewise taken only while idle.
// Reset: arst_n clears the sequencer, the done strobe and neighbor_present; cell stores
//   are not cleared. The receiver cannot stall; done lasts exactly one cycle.

module voxel_face_visibility import vfv_pkg::*; #(
	parameter int CHUNK_WIDTH  = CHUNK_WIDTH_DEF,
	parameter int CHUNK_HEIGHT = CHUNK_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       neighbor_present_we,
	input  logic [3:0] neighbor_present,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] opcode,
	input  logic [3:0] pos_x,
	input  logic [6:0] pos_y,
	input  logic [3:0] pos_z,
	input  logic [1:0] edge_side,
	input  logic [3:0] edge_pos,
	input  logic [1:0] cell_type,
	output logic       done,
	output logic [5:0] face_mask
);

	localparam int CA = $clog2(CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH);
	localparam int EA = $clog2(4 * CHUNK_WIDTH * CHUNK_HEIGHT);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_TAIL} state_t;
	typedef enum logic [1:0] {P_NONE, P_SELF, P_CELL, P_EDGE} pend_t;

	function automatic logic [CA-1:0] cell_addr(input int x, input int y, input int z);
		return CA'((x * CHUNK_HEIGHT + y) * CHUNK_WIDTH + z);
	endfunction

	function automatic logic [EA-1:0] edge_addr(input int side, input int p, input int y);
		return EA'((side * CHUNK_WIDTH + p) * CHUNK_HEIGHT + y);
	endfunction

	state_t        state_q;
	logic [2:0]    step_q;
	logic [3:0]    x_q;
	logic [6:0]    y_q;
	logic [3:0]    z_q;
	logic [1:0]    self_q;
	logic [5:0]    mask_q;
	pend_t         pend_kind_q;
	logic [2:0]    pend_face_q;
	logic          done_q;
	logic [5:0]    face_mask_q;
	logic [3:0]    present_q;

	logic          accept;
	logic          in_chunk;
	logic          edge_ok;
	vfv_mem_ctl_t  mem_ctl;
	logic [CA-1:0] cell_waddr;
	logic [EA-1:0] edge_waddr;
	logic [CA-1:0] cell_raddr;
	logic [EA-1:0] edge_raddr;
	logic [1:0]    cell_rdata;
	logic [1:0]    edge_rdata;
	pend_t         iss_kind;
	logic [1:0]    nb_type;
	logic [5:0]    mask_next;

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign face_mask = face_mask_q;
	assign accept    = start && !busy;

	// range checks on the incoming beat
	assign in_chunk = (int'(pos_x) < CHUNK_WIDTH) && (int'(pos_y) < CHUNK_HEIGHT)
		&& (int'(pos_z) < CHUNK_WIDTH);
	assign edge_ok  = (int'(edge_pos) < CHUNK_WIDTH) && (int'(pos_y) < CHUNK_HEIGHT);

	// writes go straight to the stores on the accepting edge
	assign mem_ctl.cell_we = accept && (opcode == OP_WR_CELL) && in_chunk;
	assign mem_ctl.edge_we = accept && (opcode == OP_WR_EDGE) && edge_ok;
	assign cell_waddr = cell_addr(int'(pos_x), int'(pos_y), int'(pos_z));
	assign edge_waddr = edge_addr(int'(edge_side), int'(edge_pos), int'(pos_y));

	// read issue: self cell at step 0, then one neighbor per step
	always_comb begin
		int xi;
		int yi;
		int zi;
		xi = int'(x_q);
		yi = int'(y_q);
		zi = int'(z_q);
		iss_kind   = P_NONE;
		cell_raddr = cell_addr(xi, yi, zi);
		edge_raddr = edge_addr(SIDE_PZ, xi, yi);
		case (step_q)
			3'd0: iss_kind = P_SELF;
			3'd1: begin
				if (zi + 1 >= CHUNK_WIDTH) begin
					edge_raddr = edge_addr(SIDE_PZ, xi, yi);
					iss_kind   = present_q[SIDE_PZ] ? P_EDGE : P_NONE;
				end else begin
					cell_raddr = cell_addr(xi, yi, zi + 1);
					iss_kind   = P_CELL;
				end
			end
			3'd2: begin
				if (zi == 0) begin
					edge_raddr = edge_addr(SIDE_NZ, xi, yi);
					iss_kind   = present_q[SIDE_NZ] ? P_EDGE : P_NONE;
				end else begin
					cell_raddr = cell_addr(xi, yi, zi - 1);
					iss_kind   = P_CELL;
				end
			end
			3'd3: begin
				if (xi + 1 >= CHUNK_WIDTH) begin
					edge_raddr = edge_addr(SIDE_PX, zi, yi);
					iss_kind   = present_q[SIDE_PX] ? P_EDGE : P_NONE;
				end else begin
					cell_raddr = cell_addr(xi + 1, yi, zi);
					iss_kind   = P_CELL;
				end
			end
			3'd4: begin
				if (xi == 0) begin
					edge_raddr = edge_addr(SIDE_NX, zi, yi);
					iss_kind   = present_q[SIDE_NX] ? P_EDGE : P_NONE;
				end else begin
					cell_raddr = cell_addr(xi - 1, yi, zi);
					iss_kind   = P_CELL;
				end
			end
			3'd5: begin
				// top border always hidden
				if (yi + 1 < CHUNK_HEIGHT) begin
					cell_raddr = cell_addr(xi, yi + 1, zi);
					iss_kind   = P_CELL;
				end
			end
			3'd6: begin
				// bottom border always hidden
				if (yi > 0) begin
					cell_raddr = cell_addr(xi, yi - 1, zi);
					iss_kind   = P_CELL;
				end
			end
			default: iss_kind = P_NONE;
		endcase
	end

	// evaluate the neighbor read issued last cycle
	always_comb begin
		nb_type   = (pend_kind_q == P_EDGE) ? edge_rdata : cell_rdata;
		mask_next = mask_q;
		if (pend_kind_q == P_CELL || pend_kind_q == P_EDGE) begin
			mask_next[pend_face_q] = shows(self_q, nb_type);
		end
	end

	// presence register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (neighbor_present_we) begin
			present_q <= neighbor_present;
		end
	end

	// query sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			pend_kind_q <= P_NONE;
			done_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			pend_kind_q <= (state_q == S_READ) ? iss_kind : P_NONE;
			pend_face_q <= step_q - 3'd1;
			mask_q      <= mask_next;
			if (pend_kind_q == P_SELF) begin
				self_q <= cell_rdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_QUERY) begin
						x_q    <= pos_x;
						y_q    <= pos_y;
						z_q    <= pos_z;
						mask_q <= '0;
						step_q <= '0;
						if (in_chunk) begin
							state_q <= S_READ;
						end else begin
							done_q      <= 1'b1;
							face_mask_q <= '0;
						end
					end
				end
				S_READ: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					done_q      <= 1'b1;
					face_mask_q <= (self_q == TYPE_AIR) ? 6'd0 : mask_next;
					step_q      <= '0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	vfv_store #(
		.CHUNK_WIDTH (CHUNK_WIDTH),
		.CHUNK_HEIGHT(CHUNK_HEIGHT)
	) u_store (
		.clk        (clk),
		.ctl        (mem_ctl),
		.cell_waddr (cell_waddr),
		.cell_raddr (cell_raddr),
		.edge_waddr (edge_waddr),
		.edge_raddr (edge_raddr),
		.wdata      (cell_type),
		.cell_rdata (cell_rdata),
		.edge_rdata (edge_rdata)
	);

endmodule

// ===== rtl/vfv_store.sv =====
`timescale 1ns / 1ps

module vfv_store import vfv_pkg::*; #(
	parameter int CHUNK_WIDTH  = CHUNK_WIDTH_DEF,
	parameter int CHUNK_HEIGHT = CHUNK_HEIGHT_DEF,
	localparam int CELL_DEPTH  = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH,
	localparam int EDGE_DEPTH  = 4 * CHUNK_WIDTH * CHUNK_HEIGHT,
	localparam int CA          = $clog2(CELL_DEPTH),
	localparam int EA          = $clog2(EDGE_DEPTH)
) (
	input  logic          clk,
	input  vfv_mem_ctl_t  ctl,
	input  logic [CA-1:0] cell_waddr,
	input  logic [CA-1:0] cell_raddr,
	input  logic [EA-1:0] edge_waddr,
	input  logic [EA-1:0] edge_raddr,
	input  logic [1:0]    wdata,
	output logic [1:0]    cell_rdata,
	output logic [1:0]    edge_rdata
);

	logic [1:0] cell_mem [CELL_DEPTH];
	logic [1:0] edge_mem [EDGE_DEPTH];

	// chunk cells: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctl.cell_we) begin
			cell_mem[cell_waddr] <= wdata;
		end
		cell_rdata <= cell_mem[cell_raddr];
	end

	// neighbor edge slices: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctl.edge_we) begin
			edge_mem[edge_waddr] <= wdata;
		end
		edge_rdata <= edge_mem[edge_raddr];
	end

endmodule
